// ----- hdl/assert_macros.svh -----
// assertion macros used by the exponential search sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/exs_pkg.sv -----
// shared types and constants of the exponential search engine
`timescale 1ns / 1ps

package exs_pkg;

  localparam int DEFAULT_STORE_DEPTH = 1024;
  localparam int DEFAULT_KEY_WIDTH   = 32;

  localparam int ENTRY_IDX_W   = 10;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int FOUND_W       = 10;
  localparam int ENTRY_COUNT_W = 11;
  localparam int CFG_DATA_W    = 11;
  localparam int CFG_IDX_W     = 1;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_COUNT    = 1'b0,
    CFG_COMPARE_SIGNED = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ----- hdl/exs_store.sv -----
// key store: one write port, one registered read port
`timescale 1ns / 1ps

module exs_store #(
  parameter int STORE_DEPTH = exs_pkg::DEFAULT_STORE_DEPTH,
  parameter int KEY_WIDTH   = exs_pkg::DEFAULT_KEY_WIDTH
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
  input  logic [KEY_WIDTH-1:0]           wr_data,
  input  logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
  output logic [KEY_WIDTH-1:0]           rd_data
);
  import exs_pkg::*;

  logic [KEY_WIDTH-1:0] mem [STORE_DEPTH];
  logic [KEY_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/exs_cmp.sv -----
// shared key comparator, unsigned or two's complement ordering
`timescale 1ns / 1ps

module exs_cmp #(
  parameter int KEY_WIDTH = exs_pkg::DEFAULT_KEY_WIDTH
) (
  input  logic                 signed_mode,
  input  logic [KEY_WIDTH-1:0] entry,
  input  logic [KEY_WIDTH-1:0] key,
  output exs_pkg::cmp_res_t    res
);
  import exs_pkg::*;

  logic [KEY_WIDTH-1:0] sign_flip;
  logic [KEY_WIDTH-1:0] entry_ord;
  logic [KEY_WIDTH-1:0] key_ord;

  // flipping the sign bit maps signed order onto unsigned order
  assign sign_flip = {signed_mode, {(KEY_WIDTH-1){1'b0}}};
  assign entry_ord = entry ^ sign_flip;
  assign key_ord   = key ^ sign_flip;

  always_comb begin
    res.lt = entry_ord < key_ord;
    res.eq = entry_ord == key_ord;
  end

endmodule

// ----- hdl/exs_ctrl.sv -----
// search sequencer: write beats, doubling probes, then binary search, plus result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module exs_ctrl #(
  parameter int STORE_DEPTH = exs_pkg::DEFAULT_STORE_DEPTH,
  parameter int KEY_WIDTH   = exs_pkg::DEFAULT_KEY_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [exs_pkg::ENTRY_IDX_W-1:0]   in_entry_index,
  input  logic [exs_pkg::VALUE_W-1:0]       in_item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [exs_pkg::STATUS_W-1:0]      out_status,
  output logic [exs_pkg::FOUND_W-1:0]       out_found_index,
  input  logic [exs_pkg::ENTRY_COUNT_W-1:0] entry_count,
  input  exs_pkg::cmp_res_t                 cmp_res,
  output logic [KEY_WIDTH-1:0]              cmp_key,
  output logic                              wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0]    wr_addr,
  output logic [KEY_WIDTH-1:0]              wr_data,
  output logic [$clog2(STORE_DEPTH)-1:0]    rd_addr
);
  import exs_pkg::*;

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int BW    = $clog2(STORE_DEPTH) + 2;
  localparam int CW    = (BW > ENTRY_COUNT_W) ? BW : ENTRY_COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PROBE0 = 5'b00010,
    S_DOUBLE = 5'b00100,
    S_BINARY = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [BW-1:0]        count_r, count_nxt;
  logic [BW-1:0]        bound_r, bound_nxt;
  logic [BW-1:0]        lo_r, lo_nxt;
  logic [BW-1:0]        hi_r, hi_nxt;
  logic [BW-1:0]        mid_r, mid_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [FOUND_W-1:0]   res_found_r, res_found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [FOUND_W-1:0]   out_found_r, out_found_nxt;
  logic [BW-1:0]        addr_nxt;

  logic                 in_accept;
  logic                 out_free;
  logic                 wr_in_range;
  logic [CW-1:0]        ec_ext;
  logic [BW-1:0]        count_in;
  logic [BW-1:0]        bound_dbl;
  logic [BW-1:0]        ge_lo;
  logic [BW-1:0]        ge_sum;
  logic [BW-1:0]        of_hi;
  logic [BW-1:0]        of_sum;
  logic [BW-1:0]        up_lo;
  logic [BW-1:0]        up_sum;
  logic [BW-1:0]        dn_hi;
  logic [BW-1:0]        dn_sum;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  assign wr_in_range = 32'(in_entry_index) < 32'(STORE_DEPTH);
  assign wr_addr     = IDX_W'(in_entry_index);
  assign wr_data     = KEY_WIDTH'(in_item_value);

  assign ec_ext   = CW'(entry_count);
  assign count_in = (ec_ext > CW'(STORE_DEPTH)) ? BW'(STORE_DEPTH) : BW'(ec_ext);

  // candidate midpoints for every branch, in parallel with the compare
  assign bound_dbl = {bound_r[BW-2:0], 1'b0};
  assign ge_lo     = bound_r >> 1;
  assign ge_sum    = ge_lo + bound_r;
  assign of_hi     = count_r - BW'(1);
  assign of_sum    = bound_r + of_hi;
  assign up_lo     = mid_r + BW'(1);
  assign up_sum    = up_lo + hi_r;
  assign dn_hi     = mid_r - BW'(1);
  assign dn_sum    = lo_r + dn_hi;

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    bound_nxt      = bound_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    addr_nxt       = '0;
    wr_en          = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_operation == OP_WRITE) begin
            wr_en          = wr_in_range;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_found_nxt  = FOUND_W'(in_entry_index);
          end else begin
            key_nxt   = KEY_WIDTH'(in_item_value);
            count_nxt = count_in;
            if (count_in == '0) begin
              res_status_nxt = ST_EMPTY;
              res_found_nxt  = '0;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_PROBE0;
            end
          end
        end
      end
      S_PROBE0: begin
        if (cmp_res.eq) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = '0;
          state_nxt      = S_DONE;
        end else if (count_r == BW'(1)) begin
          res_status_nxt = ST_NOT_FOUND;
          res_found_nxt  = '0;
          state_nxt      = S_DONE;
        end else begin
          bound_nxt = BW'(1);
          addr_nxt  = BW'(1);
          state_nxt = S_DOUBLE;
        end
      end
      S_DOUBLE: begin
        if (!cmp_res.lt) begin
          lo_nxt    = ge_lo;
          hi_nxt    = bound_r;
          mid_nxt   = ge_sum >> 1;
          addr_nxt  = ge_sum >> 1;
          state_nxt = S_BINARY;
        end else if (bound_dbl < count_r) begin
          bound_nxt = bound_dbl;
          addr_nxt  = bound_dbl;
        end else begin
          lo_nxt    = bound_r;
          hi_nxt    = of_hi;
          mid_nxt   = of_sum >> 1;
          addr_nxt  = of_sum >> 1;
          state_nxt = S_BINARY;
        end
      end
      S_BINARY: begin
        if (cmp_res.eq) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = FOUND_W'(mid_r);
          state_nxt      = S_DONE;
        end else if (cmp_res.lt) begin
          if (up_lo > hi_r) begin
            res_status_nxt = ST_NOT_FOUND;
            res_found_nxt  = '0;
            state_nxt      = S_DONE;
          end else begin
            lo_nxt   = up_lo;
            mid_nxt  = up_sum >> 1;
            addr_nxt = up_sum >> 1;
          end
        end else begin
          if (mid_r == '0 || dn_hi < lo_r) begin
            res_status_nxt = ST_NOT_FOUND;
            res_found_nxt  = '0;
            state_nxt      = S_DONE;
          end else begin
            hi_nxt   = dn_hi;
            mid_nxt  = dn_sum >> 1;
            addr_nxt = dn_sum >> 1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    count_r      <= count_nxt;
    bound_r      <= bound_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign rd_addr         = IDX_W'(addr_nxt);
  assign cmp_key         = key_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;

  `ASSERT_CLK(a_no_wr_busy, (state_r != S_IDLE) |-> !wr_en, "store written during a search")
  `ASSERT_CLK(a_bin_range, (state_r == S_BINARY) |-> (lo_r <= mid_r && mid_r <= hi_r && hi_r < count_r), "binary probe outside its range")
  `ASSERT_CLK(a_dbl_bound, (state_r == S_DOUBLE) |-> (bound_r != '0 && bound_r < count_r), "doubling probe beyond entry count")
  `ASSERT_NEXT(a_done_hold, state_r == S_DONE && out_valid_r && out_stall, state_r == S_DONE, "search result dropped while output stalled")

endmodule

// ----- hdl/exponential_search_engine.sv -----
// exponential search engine top level: config registers, sequencer, comparator, key store
//
//   beat     direction  fields
//   in_      input      in_operation, in_entry_index, in_item_value
//   out_     output     out_status, out_found_index
//   cfg_     input      cfg_index, cfg_data (write only, on cfg_wr_en)
//
// a write beat's result is registered at the accept edge
// a search holds the input through probe 0, d doubling and b binary probes and the
// result hand-off, one probe per cycle through the single registered read port of
// the key store
// rst_n clears the sequencer, the result valid and both config registers
// a stalled output holds the result; the next beat waits until it is taken

`timescale 1ns / 1ps

module exponential_search_engine #(
  parameter int STORE_DEPTH = exs_pkg::DEFAULT_STORE_DEPTH,
  parameter int KEY_WIDTH   = exs_pkg::DEFAULT_KEY_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [exs_pkg::ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [exs_pkg::VALUE_W-1:0]     in_item_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [exs_pkg::STATUS_W-1:0]    out_status,
  output logic [exs_pkg::FOUND_W-1:0]     out_found_index,
  input  logic                            cfg_wr_en,
  input  logic [exs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [exs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import exs_pkg::*;

  localparam int IDX_W = $clog2(STORE_DEPTH);

  logic [ENTRY_COUNT_W-1:0] entry_count_r;
  logic                     compare_signed_r;
  cmp_res_t                 cmp_res;
  logic [KEY_WIDTH-1:0]     cmp_key;
  logic [KEY_WIDTH-1:0]     rd_data;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [KEY_WIDTH-1:0]     wr_data;
  logic [IDX_W-1:0]         rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r    <= '0;
      compare_signed_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENTRY_COUNT: begin
          entry_count_r <= ENTRY_COUNT_W'(cfg_data);
        end
        CFG_COMPARE_SIGNED: begin
          compare_signed_r <= cfg_data[0];
        end
      endcase
    end
  end

  exs_ctrl #(
    .STORE_DEPTH(STORE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_entry_index (in_entry_index),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found_index(out_found_index),
    .entry_count    (entry_count_r),
    .cmp_res        (cmp_res),
    .cmp_key        (cmp_key),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr        (rd_addr)
  );

  exs_cmp #(
    .KEY_WIDTH(KEY_WIDTH)
  ) u_cmp (
    .signed_mode(compare_signed_r),
    .entry      (rd_data),
    .key        (cmp_key),
    .res        (cmp_res)
  );

  exs_store #(
    .STORE_DEPTH(STORE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule
